/* rtl/assert_macros.svh */
// Assertion macros used by the back end (vna_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, clocked on aclk, off while in reset.
`define VNA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define VNA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/vna_pkg.sv */
// Shared types and constants for the vertex normal averaging core.
`timescale 1ns / 1ps
package vna_pkg;
    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_POS_WIDTH    = 16;
    localparam int DEF_ACC_WIDTH    = 24;
    localparam int QUEUE_DEPTH      = 4;
    localparam int FRAC_BITS        = 14;
    localparam int UNIT_ONE         = 16384;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_TRI  = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_TRI,
        OP_READ,
        OP_READ_OOR
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [9:0]  index;
        logic [9:0]  tri_a;
        logic [9:0]  tri_b;
        logic [9:0]  tri_c;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] pos_z;
    } item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_PA,
        S_PB,
        S_PC,
        S_PW,
        S_CROSS,
        S_SQ,
        S_ROOT,
        S_DIV,
        S_AR,
        S_AW,
        S_RR,
        S_RW,
        S_OUT
    } st_t;
endpackage

/* rtl/vertex_normal_averaging_core.sv */
// Top level of the vertex normal averaging core.
// The back end handles one queued transaction at a time, and a read or triangle whose
// accumulator or normal is zero skips the divisions. For triangles and reads the
// one-bit-per-cycle square root and the three 15-step divisions dominate. A 4-entry queue
// keeps taking transactions while the back end works, until it is full.
// aresetn (synchronous) clears control state only; memories are undefined until loaded.
`timescale 1ns / 1ps
module vertex_normal_averaging_core
    import vna_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int POS_WIDTH    = DEF_POS_WIDTH,
    parameter int ACC_WIDTH    = DEF_ACC_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,  // vertex_index, pos_x, pos_y, pos_z, tri_a, tri_b, tri_c
    input  logic [1:0]  s_tuser,  // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata   // out_index, normal_x, normal_y, normal_z, zero pad
);
    logic  item_valid, item_ready;
    item_t item;

    vna_front #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    vna_back #(
        .MAX_VERTICES(MAX_VERTICES),
        .POS_WIDTH   (POS_WIDTH),
        .ACC_WIDTH   (ACC_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );
endmodule

/* rtl/vna_front.sv */
// Front end: accepts stream transactions, classifies them and queues the valid ones.
`timescale 1ns / 1ps
module vna_front
    import vna_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,  // vertex_index, pos_x, pos_y, pos_z, tri_a, tri_b, tri_c
    input  logic [1:0]  s_tuser,  // kind
    output logic        item_valid,
    input  logic        item_ready,
    output item_t       item
);
    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    item_t          queue_mem [QUEUE_DEPTH];
    logic [QAW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [QCW-1:0] count_reg, count_next;
    item_t          cls;
    logic           keep;
    logic           push, pop;

    function automatic logic in_range(input logic [9:0] v);
        in_range = 32'(v) < 32'(MAX_VERTICES);
    endfunction

    always_comb begin
        cls.index = s_tdata[9:0];
        cls.pos_x = s_tdata[25:10];
        cls.pos_y = s_tdata[41:26];
        cls.pos_z = s_tdata[57:42];
        cls.tri_a = s_tdata[67:58];
        cls.tri_b = s_tdata[77:68];
        cls.tri_c = s_tdata[87:78];
        cls.op    = OP_LOAD;
        keep      = 1'b0;
        case (s_tuser)
            KIND_LOAD: begin
                keep = in_range(cls.index);
            end
            KIND_TRI: begin
                cls.op = OP_TRI;
                keep   = in_range(cls.tri_a) && in_range(cls.tri_b) && in_range(cls.tri_c);
            end
            KIND_READ: begin
                cls.op = in_range(cls.index) ? OP_READ : OP_READ_OOR;
                keep   = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready   = count_reg != QCW'(QUEUE_DEPTH);
    assign item_valid = count_reg != '0;
    assign item       = queue_mem[head_reg];
    assign push       = s_tvalid && s_tready && keep;
    assign pop        = item_valid && item_ready;

    always_comb begin
        head_next  = pop  ? head_reg + 1'b1 : head_reg;
        tail_next  = push ? tail_reg + 1'b1 : tail_reg;
        count_next = count_reg + QCW'(push) - QCW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[tail_reg] <= cls;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end
endmodule

/* rtl/vna_back.sv */
// Back end: position and accumulator memories, cross product and normalizer.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vna_back
    import vna_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int POS_WIDTH    = DEF_POS_WIDTH,
    parameter int ACC_WIDTH    = DEF_ACC_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata
);
    localparam int IW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EW   = POS_WIDTH + 1;
    localparam int CW0  = 2 * POS_WIDTH + 3;
    localparam int CW   = (CW0 > ACC_WIDTH) ? CW0 : ACC_WIDTH;
    localparam int HW   = (CW + 1) / 2;
    localparam int MWF  = 2 * HW;
    localparam int L2W  = 2 * MWF + 2;
    localparam int SW   = L2W / 2;
    localparam int RW   = SW + 1;
    localparam int DW   = SW + 1;
    localparam int QW   = FRAC_BITS + 1;
    localparam int CNTW = $clog2(SW + 1);
    localparam int SUMW = ((ACC_WIDTH > 16) ? ACC_WIDTH : 16) + 1;
    localparam logic signed [SUMW-1:0] ACC_HI = SUMW'((64'sd1 <<< (ACC_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SUMW-1:0] ACC_LO = -ACC_HI - SUMW'(1);

    st_t state_reg, state_next;
    item_t item_reg;

    logic [3*POS_WIDTH-1:0] pos_mem [MAX_VERTICES];
    logic [3*ACC_WIDTH-1:0] acc_mem [MAX_VERTICES];
    logic [3*POS_WIDTH-1:0] pos_rdata_reg;
    logic [3*ACC_WIDTH-1:0] acc_rdata_reg;
    logic [IW-1:0]          pos_raddr, acc_raddr, acc_waddr;
    logic                   pos_we, acc_we;
    logic [3*ACC_WIDTH-1:0] acc_wdata;

    logic [3*POS_WIDTH-1:0] pa_reg, pb_reg;
    logic signed [EW-1:0]   e1_reg [3];
    logic signed [EW-1:0]   e2_reg [3];
    logic signed [CW-1:0]   cr_reg [3];
    logic [L2W-1:0]         len2_reg;
    logic [SW-1:0]          root_reg;
    logic [RW-1:0]          irem_reg;
    logic [DW-1:0]          drem_reg;
    logic [QW-1:0]          quot_reg;
    logic signed [15:0]     nrm_reg [3];
    logic [CNTW-1:0]        cnt_reg;
    logic [1:0]             k_reg, j_reg, sel_reg;

    logic                   m_valid_reg;
    logic [63:0]            m_data_reg;
    logic                   out_load;

    // datapath terms
    logic signed [EW-1:0]   mul_a, mul_b;
    logic signed [2*EW-1:0] prod;
    logic signed [CW-1:0]   cr_sel, cr_neg;
    logic [MWF-1:0]         mag;
    logic [2*HW-1:0]        sq_prod;
    logic [L2W-1:0]         sq_term;
    logic [SW+2:0]          rt_t, rt_trial;
    logic [DW-1:0]          dv_in;
    logic                   dv_ge;
    logic [QW-1:0]          q_new, q_clip;
    logic                   last_root, last_div;

    function automatic logic [ACC_WIDTH-1:0] sat_add(input logic [ACC_WIDTH-1:0] a,
                                                    input logic signed [15:0] n);
        logic signed [SUMW-1:0] s;
        s = SUMW'($signed(a)) + SUMW'(n);
        if (s > ACC_HI) begin
            s = ACC_HI;
        end else if (s < ACC_LO) begin
            s = ACC_LO;
        end
        sat_add = ACC_WIDTH'(s);
    endfunction

    function automatic logic signed [CW-1:0] pos_sub(input logic [POS_WIDTH-1:0] p,
                                                     input logic [POS_WIDTH-1:0] q);
        pos_sub = CW'($signed(p)) - CW'($signed(q));
    endfunction

    // cross product operand schedule: even steps set, odd steps subtract
    always_comb begin
        case (cnt_reg[2:0])
            3'd0:    begin mul_a = e1_reg[1]; mul_b = e2_reg[2]; end
            3'd1:    begin mul_a = e1_reg[2]; mul_b = e2_reg[1]; end
            3'd2:    begin mul_a = e1_reg[2]; mul_b = e2_reg[0]; end
            3'd3:    begin mul_a = e1_reg[0]; mul_b = e2_reg[2]; end
            3'd4:    begin mul_a = e1_reg[0]; mul_b = e2_reg[1]; end
            default: begin mul_a = e1_reg[1]; mul_b = e2_reg[0]; end
        endcase
        prod   = mul_a * mul_b;
        cr_sel = cr_reg[k_reg];
        cr_neg = -cr_sel;
        mag    = MWF'($unsigned(cr_sel[CW-1] ? cr_neg : cr_sel));
        // square as partial products of the two magnitude halves
        case (j_reg)
            2'd0:    begin
                sq_prod = mag[MWF-1:HW] * mag[MWF-1:HW];
                sq_term = L2W'(sq_prod) << (2 * HW);
            end
            2'd1:    begin
                sq_prod = mag[MWF-1:HW] * mag[HW-1:0];
                sq_term = L2W'(sq_prod) << (HW + 1);
            end
            default: begin
                sq_prod = mag[HW-1:0] * mag[HW-1:0];
                sq_term = L2W'(sq_prod);
            end
        endcase
        rt_t      = {irem_reg, len2_reg[L2W-1:L2W-2]};
        rt_trial  = {1'b0, root_reg, 2'b01};
        dv_in     = (cnt_reg == '0) ? DW'(mag) : {drem_reg[DW-2:0], 1'b0};
        dv_ge     = dv_in >= DW'(root_reg);
        q_new     = {((cnt_reg == '0) ? (QW-1)'(0) : quot_reg[QW-2:0]), dv_ge};
        q_clip    = (q_new > QW'(UNIT_ONE)) ? QW'(UNIT_ONE) : q_new;
        last_root = cnt_reg == CNTW'(SW - 1);
        last_div  = cnt_reg == CNTW'(FRAC_BITS);
        out_load  = (state_reg == S_OUT) && (!m_valid_reg || m_tready);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (item_valid) begin
                    case (item.op)
                        OP_LOAD: state_next = S_LOAD;
                        OP_TRI:  state_next = S_PA;
                        OP_READ: state_next = S_RR;
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_LOAD:  state_next = S_IDLE;
            S_PA:    state_next = S_PB;
            S_PB:    state_next = S_PC;
            S_PC:    state_next = S_PW;
            S_PW:    state_next = S_CROSS;
            S_CROSS: if (cnt_reg == CNTW'(5)) state_next = S_SQ;
            S_SQ:    if (k_reg == 2'd2 && j_reg == 2'd2) state_next = S_ROOT;
            S_ROOT: begin
                if (last_root) begin
                    if (rt_t >= rt_trial || root_reg != '0) begin
                        state_next = S_DIV;
                    end else begin
                        state_next = (item_reg.op == OP_TRI) ? S_AR : S_OUT;
                    end
                end
            end
            S_DIV: begin
                if (last_div && k_reg == 2'd2) begin
                    state_next = (item_reg.op == OP_TRI) ? S_AR : S_OUT;
                end
            end
            S_AR:    state_next = S_AW;
            S_AW:    state_next = (sel_reg == 2'd2) ? S_IDLE : S_AR;
            S_RR:    state_next = S_RW;
            S_RW:    state_next = S_SQ;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // memory controls and handshake outputs
    always_comb begin
        item_ready = state_reg == S_IDLE;
        pos_we     = state_reg == S_LOAD;
        acc_we     = (state_reg == S_LOAD) || (state_reg == S_AW);
        case (state_reg)
            S_PA:    pos_raddr = IW'(item_reg.tri_a);
            S_PB:    pos_raddr = IW'(item_reg.tri_b);
            default: pos_raddr = IW'(item_reg.tri_c);
        endcase
        case (sel_reg)
            2'd0:    acc_raddr = IW'(item_reg.tri_a);
            2'd1:    acc_raddr = IW'(item_reg.tri_b);
            default: acc_raddr = IW'(item_reg.tri_c);
        endcase
        if (state_reg == S_RR) begin
            acc_raddr = IW'(item_reg.index);
        end
        if (state_reg == S_LOAD) begin
            acc_waddr = IW'(item_reg.index);
            acc_wdata = '0;
        end else begin
            acc_waddr = acc_raddr;
            acc_wdata = {sat_add(acc_rdata_reg[3*ACC_WIDTH-1:2*ACC_WIDTH], nrm_reg[2]),
                         sat_add(acc_rdata_reg[2*ACC_WIDTH-1:ACC_WIDTH], nrm_reg[1]),
                         sat_add(acc_rdata_reg[ACC_WIDTH-1:0], nrm_reg[0])};
        end
    end

    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[IW'(item_reg.index)] <= {POS_WIDTH'(item_reg.pos_z),
                                             POS_WIDTH'(item_reg.pos_y),
                                             POS_WIDTH'(item_reg.pos_x)};
        end
        pos_rdata_reg <= pos_mem[pos_raddr];
    end

    always_ff @(posedge aclk) begin
        if (acc_we) begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        acc_rdata_reg <= acc_mem[acc_raddr];
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                item_reg   <= item;
                nrm_reg[0] <= '0;
                nrm_reg[1] <= '0;
                nrm_reg[2] <= '0;
                sel_reg    <= '0;
            end
            S_PB: pa_reg <= pos_rdata_reg;
            S_PC: pb_reg <= pos_rdata_reg;
            S_PW: begin
                for (int i = 0; i < 3; i++) begin
                    e1_reg[i] <= EW'(pos_sub(pb_reg[i*POS_WIDTH +: POS_WIDTH],
                                             pa_reg[i*POS_WIDTH +: POS_WIDTH]));
                    e2_reg[i] <= EW'(pos_sub(pos_rdata_reg[i*POS_WIDTH +: POS_WIDTH],
                                             pa_reg[i*POS_WIDTH +: POS_WIDTH]));
                end
                cnt_reg <= '0;
            end
            S_CROSS: begin
                if (cnt_reg[0]) begin
                    cr_reg[cnt_reg[2:1]] <= cr_reg[cnt_reg[2:1]] - CW'(prod);
                end else begin
                    cr_reg[cnt_reg[2:1]] <= CW'(prod);
                end
                cnt_reg  <= cnt_reg + 1'b1;
                k_reg    <= '0;
                j_reg    <= '0;
                len2_reg <= '0;
            end
            S_RW: begin
                for (int i = 0; i < 3; i++) begin
                    cr_reg[i] <= CW'($signed(acc_rdata_reg[i*ACC_WIDTH +: ACC_WIDTH]));
                end
                k_reg    <= '0;
                j_reg    <= '0;
                len2_reg <= '0;
            end
            S_SQ: begin
                len2_reg <= len2_reg + sq_term;
                if (j_reg == 2'd2) begin
                    j_reg <= '0;
                    k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 1'b1;
                end else begin
                    j_reg <= j_reg + 1'b1;
                end
                cnt_reg  <= '0;
                root_reg <= '0;
                irem_reg <= '0;
            end
            S_ROOT: begin
                // one result bit per step from the top pair of the square
                len2_reg <= len2_reg << 2;
                if (rt_t >= rt_trial) begin
                    irem_reg <= RW'(rt_t - rt_trial);
                    root_reg <= {root_reg[SW-2:0], 1'b1};
                end else begin
                    irem_reg <= RW'(rt_t);
                    root_reg <= {root_reg[SW-2:0], 1'b0};
                end
                cnt_reg <= last_root ? '0 : cnt_reg + 1'b1;
                k_reg   <= '0;
            end
            S_DIV: begin
                drem_reg <= dv_ge ? dv_in - DW'(root_reg) : dv_in;
                quot_reg <= q_new;
                if (last_div) begin
                    nrm_reg[k_reg] <= cr_sel[CW-1] ? -16'(q_clip) : 16'(q_clip);
                    cnt_reg        <= '0;
                    k_reg          <= k_reg + 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            S_AW: sel_reg <= sel_reg + 1'b1;
            default: begin
            end
        endcase
        if (out_load) begin
            m_data_reg <= {6'd0, nrm_reg[2], nrm_reg[1], nrm_reg[0], item_reg.index};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `VNA_ASSERT_IMPL(a_div_root_nonzero, state_reg == S_DIV, root_reg != '0)
    `VNA_ASSERT_IMPL(a_acc_write_state, acc_we, state_reg == S_AW || state_reg == S_LOAD)
    `VNA_ASSERT_NEXT(a_out_loaded, out_load, m_valid_reg)
endmodule
